FILE: src/lscf_pkg.sv
package lscf_pkg;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  // configuration register indexes
  localparam logic [2:0] CFG_PROGRAM_OPS    = 3'd0;
  localparam logic [2:0] CFG_PROGRAM_LENGTH = 3'd1;
  localparam logic [2:0] CFG_ARG_ZERO       = 3'd2;
  localparam logic [2:0] CFG_ARG_ONE        = 3'd3;
  localparam logic [2:0] CFG_ARG_TWO        = 3'd4;
  localparam logic [2:0] CFG_ARG_THREE      = 3'd5;
  localparam logic [2:0] CFG_TAG_LENGTHS    = 3'd6;

  typedef enum logic [2:0] {
    OP_TOGGLE = 3'd0,
    OP_PASS   = 3'd1,
    OP_REJECT = 3'd2,
    OP_MOVE   = 3'd3,
    OP_JUMP   = 3'd4,
    OP_FIND   = 3'd5,
    OP_SKIP   = 3'd6
  } op_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic emit_prefix;
    logic emit_byte;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_decide;
    logic decided;
    logic passing;
    logic eval_done;
    logic pass_now;
    logic out_free;
    logic prefix_last;
  } ctrl_status_t;

endpackage

FILE: src/line_selection_command_filter.sv
// line selection filter: bytes of a newline-ended text stream come in on the
// in_ channel (in_byte, in_stream_end marks the last byte of a stream); bytes
// of each selected line leave on the out_ channel, out_run_last set on the last
// byte produced by one input transaction.
// the cfg_ channel writes the program: index 0 opcodes, 1 length, 2..5 the
// four arguments, 6 tag lengths; write it only while the block is idle.
// handling of each input byte, one at a time:
//   byte that only fills the tag buffer or is dropped: accept, then finish
//   byte of a line already passing: accept, emit, finish, plus output wait
//   byte that settles a line: accept, up to PROGRAM_DEPTH+1 program steps
//   (one command a cycle), then one release per buffered byte
//   (up to TAG_BYTES) when the line passes, then finish
// the program walker and the single output register drive these steps.
// the output register lets a finished result wait for the receiver while the
// next input transaction is taken; while the receiver stalls, release of
// further bytes halts and in_ready stays low until the run is out.
// reset clears the program registers, line counters, pass flag and the
// output valid flag; cfg_ready is always high.
module line_selection_command_filter #(
  parameter int PROGRAM_DEPTH = 4,
  parameter int TAG_BYTES     = 8,
  parameter int COUNT_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  lscf_pkg::ctrl_cmd_t    cmd;
  lscf_pkg::ctrl_status_t st;

  assign cfg_ready = 1'b1;

  lscf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lscf_dp #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .TAG_BYTES     (TAG_BYTES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_byte       (in_byte),
    .in_stream_end (in_stream_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .st            (st)
  );

  // one transaction at a time: an accepted byte always takes the block busy
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // wrapping up a byte always returns the block to ready
  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_ready)
    else $error("block did not return to ready after finishing a byte");

  // bytes are only released into a free output register
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_prefix || cmd.emit_byte) |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

FILE: src/lscf_ctrl.sv
module lscf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lscf_pkg::ctrl_status_t st,
  output lscf_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT_PREFIX,
    S_EMIT_BYTE,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.need_decide) begin
            state_nxt = S_EVAL;
          end else if (st.decided && st.passing) begin
            state_nxt = S_EMIT_BYTE;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_EVAL: begin
        // one command per cycle until the line is settled
        cmd.eval = 1'b1;
        if (st.eval_done) begin
          state_nxt = st.pass_now ? S_EMIT_PREFIX : S_FINISH;
        end
      end
      S_EMIT_PREFIX: begin
        if (st.out_free) begin
          cmd.emit_prefix = 1'b1;
          if (st.prefix_last) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_EMIT_BYTE: begin
        if (st.out_free) begin
          cmd.emit_byte = 1'b1;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/lscf_dp.sv
module lscf_dp #(
  parameter int PROGRAM_DEPTH = 4,
  parameter int TAG_BYTES     = 8,
  parameter int COUNT_BITS    = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_byte,
  input  logic                   in_stream_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_run_last,
  input  logic                   cfg_valid,
  input  logic [2:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  input  lscf_pkg::ctrl_cmd_t    cmd,
  output lscf_pkg::ctrl_status_t st
);

  localparam int FW = $clog2(TAG_BYTES + 1);
  localparam int IW = (TAG_BYTES > 1) ? $clog2(TAG_BYTES) : 1;
  localparam int PW = $clog2(PROGRAM_DEPTH + 1);
  localparam logic [FW-1:0] TAG_FULL = FW'(TAG_BYTES);
  localparam logic [3:0]    TAG_MAX4 = 4'(TAG_BYTES);
  localparam logic [2:0]    DEPTH3   = 3'(PROGRAM_DEPTH);

  // configuration registers
  logic [11:0] ops_r;
  logic [2:0]  len_r;
  logic [63:0] arg_r [4];
  logic [15:0] tags_r;

  // stream state
  logic [7:0]            store_r [TAG_BYTES];
  logic [FW-1:0]         fill_r;
  logic [COUNT_BITS-1:0] line_r;
  logic [PW-1:0]         ptr_r;
  logic                  flag_r;
  logic [COUNT_BITS-1:0] jump_r;
  logic                  decided_r;
  logic                  passing_r;
  logic [FW-1:0]         emit_idx_r;
  logic [7:0]            byte_r;
  logic                  end_r;
  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic                  out_last_r;

  // accept side
  logic          line_end_in;
  logic [FW-1:0] fill_after;
  logic          line_end_r;

  assign line_end_in = in_stream_end || (in_byte == lscf_pkg::NEWLINE_BYTE);
  assign fill_after  = (fill_r < TAG_FULL) ? (fill_r + FW'(1)) : fill_r;
  assign line_end_r  = end_r || (byte_r == lscf_pkg::NEWLINE_BYTE);

  // one program step
  logic [2:0]      n_eff;
  logic [1:0]      kidx;
  lscf_pkg::op_t   op;
  logic [63:0]     arg;
  logic [3:0]      tlen;
  logic [3:0]      tlen_eff;
  logic            mismatch;
  logic            match;
  logic [PW-1:0]   ptr_e;
  logic            flag_e;
  logic [COUNT_BITS-1:0] jump_e;
  logic            stop;

  assign n_eff    = (len_r > DEPTH3) ? DEPTH3 : len_r;
  assign kidx     = 2'(ptr_r);
  assign op       = lscf_pkg::op_t'(ops_r[3*kidx +: 3]);
  assign arg      = arg_r[kidx];
  assign tlen     = tags_r[4*kidx +: 4];
  assign tlen_eff = (tlen > TAG_MAX4) ? TAG_MAX4 : tlen;

  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < TAG_BYTES; i++) begin
      if ((4'(i) < tlen_eff) && (store_r[i] != arg[8*i +: 8])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign match = (4'(fill_r) >= tlen_eff) && !mismatch;

  always_comb begin
    ptr_e  = ptr_r;
    flag_e = flag_r;
    jump_e = jump_r;
    stop   = 1'b0;
    if (3'(ptr_r) >= n_eff) begin
      stop = 1'b1;
    end else begin
      case (op)
        lscf_pkg::OP_TOGGLE: begin
          flag_e = !flag_r;
          ptr_e  = ptr_r + PW'(1);
        end
        lscf_pkg::OP_PASS: begin
          flag_e = 1'b1;
          ptr_e  = ptr_r + PW'(1);
        end
        lscf_pkg::OP_REJECT: begin
          flag_e = 1'b0;
          ptr_e  = ptr_r + PW'(1);
        end
        lscf_pkg::OP_MOVE: begin
          if (64'(line_r) < arg) begin
            stop = 1'b1;
          end else begin
            ptr_e = ptr_r + PW'(1);
          end
        end
        lscf_pkg::OP_JUMP: begin
          if (64'(jump_r) < arg) begin
            stop = 1'b1;
            if (jump_r != '1) begin
              jump_e = jump_r + COUNT_BITS'(1);
            end
          end else begin
            jump_e = '0;
            ptr_e  = ptr_r + PW'(1);
          end
        end
        lscf_pkg::OP_FIND: begin
          if (match) begin
            ptr_e = ptr_r + PW'(1);
          end else begin
            stop = 1'b1;
          end
        end
        lscf_pkg::OP_SKIP: begin
          // skip ends the line either way, advancing only on a match
          stop = 1'b1;
          if (match) begin
            ptr_e = ptr_r + PW'(1);
          end
        end
        default: begin
          ptr_e = ptr_r + PW'(1);
        end
      endcase
    end
  end

  always_comb begin
    st.need_decide = !decided_r && ((fill_after >= TAG_FULL) || line_end_in);
    st.decided     = decided_r;
    st.passing     = passing_r;
    st.eval_done   = stop;
    st.pass_now    = flag_e;
    st.out_free    = !out_valid_r || out_ready;
    st.prefix_last = (emit_idx_r == FW'(fill_r - FW'(1)));
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
      end_r  <= in_stream_end;
      if (!decided_r && (fill_r < TAG_FULL)) begin
        store_r[fill_r[IW-1:0]] <= in_byte;
      end
    end
    if (cmd.emit_prefix) begin
      out_byte_r <= store_r[emit_idx_r[IW-1:0]];
      out_last_r <= st.prefix_last;
    end else if (cmd.emit_byte) begin
      out_byte_r <= byte_r;
      out_last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ops_r       <= '0;
      len_r       <= '0;
      for (int i = 0; i < 4; i++) begin
        arg_r[i] <= '0;
      end
      tags_r      <= '0;
      fill_r      <= '0;
      line_r      <= '0;
      ptr_r       <= '0;
      flag_r      <= 1'b0;
      jump_r      <= '0;
      decided_r   <= 1'b0;
      passing_r   <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lscf_pkg::CFG_PROGRAM_OPS:    ops_r    <= cfg_data[11:0];
          lscf_pkg::CFG_PROGRAM_LENGTH: len_r    <= cfg_data[2:0];
          lscf_pkg::CFG_ARG_ZERO:       arg_r[0] <= cfg_data;
          lscf_pkg::CFG_ARG_ONE:        arg_r[1] <= cfg_data;
          lscf_pkg::CFG_ARG_TWO:        arg_r[2] <= cfg_data;
          lscf_pkg::CFG_ARG_THREE:      arg_r[3] <= cfg_data;
          lscf_pkg::CFG_TAG_LENGTHS:    tags_r   <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (cmd.emit_prefix || cmd.emit_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.accept) begin
        emit_idx_r <= '0;
        if (!decided_r) begin
          fill_r <= fill_after;
        end
      end

      if (cmd.eval) begin
        ptr_r  <= ptr_e;
        flag_r <= flag_e;
        jump_r <= jump_e;
        if (stop) begin
          decided_r <= 1'b1;
          passing_r <= flag_e;
        end
      end

      if (cmd.emit_prefix) begin
        emit_idx_r <= emit_idx_r + FW'(1);
      end

      if (cmd.finish) begin
        // end of stream starts a fresh one
        if (end_r) begin
          fill_r    <= '0;
          line_r    <= '0;
          ptr_r     <= '0;
          flag_r    <= 1'b0;
          jump_r    <= '0;
          decided_r <= 1'b0;
          passing_r <= 1'b0;
        end else if (line_end_r) begin
          fill_r    <= '0;
          decided_r <= 1'b0;
          passing_r <= 1'b0;
          if (line_r != '1) begin
            line_r <= line_r + COUNT_BITS'(1);
          end
        end
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

endmodule
